/* design/lzcd_pkg.sv */
// Shared types, codes and helpers for the LZ command decompressor.
`timescale 1ns / 1ps

package lzcd_pkg;

    // Decoder phases of the command stream
    typedef enum logic [2:0] {
        PH_CMD,
        PH_LONG,
        PH_LIT,
        PH_VAL_A,
        PH_VAL_B,
        PH_OFS_HI,
        PH_OFS_LO,
        PH_EMIT
    } phase_t;

    // Command codes
    localparam logic [2:0] CMD_LITERAL = 3'd0;
    localparam logic [2:0] CMD_REPEAT  = 3'd1;
    localparam logic [2:0] CMD_ALT     = 3'd2;
    localparam logic [2:0] CMD_ZERO    = 3'd3;
    localparam logic [2:0] CMD_COPY    = 3'd4;
    localparam logic [2:0] CMD_FLIP    = 3'd5;
    localparam logic [2:0] CMD_BACK    = 3'd6;
    localparam logic [2:0] CMD_LONG    = 3'd7;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_CMD   = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE = 3'd2;
    localparam logic [2:0] ST_RANGE     = 3'd3;
    localparam logic [2:0] ST_KIND      = 3'd4;

    // Input kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [7:0]  END_MARK    = 8'hFF;
    localparam logic [15:0] LIMIT_RESET = 16'd8192;

    // Pre-decoded input item, as held in the queue
    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic       is_end;
        logic       is_long;
        logic [2:0] code;
        logic [4:0] len_lo;
        logic [1:0] len_hi;
    } item_t;

    // Bit-order reversal of one byte
    function automatic logic [7:0] flip_bits(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[7 - i] = v[i];
        end
        return r;
    endfunction

    // First phase of a run for a given command
    function automatic phase_t start_phase(input logic [2:0] cmd);
        phase_t p;
        unique case (cmd)
            CMD_LITERAL:       p = PH_LIT;
            CMD_REPEAT:        p = PH_VAL_A;
            CMD_ALT:           p = PH_VAL_A;
            CMD_ZERO:          p = PH_EMIT;
            default:           p = PH_OFS_HI;
        endcase
        return p;
    endfunction

endpackage

/* design/lzcd_front.sv */
// Front end: accepts input items, pre-decodes command fields, two-entry queue.
`timescale 1ns / 1ps

module lzcd_front
    import lzcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tuser,   // [0] op
    output logic       q_valid,
    input  logic       q_pop,
    output item_t      q_item
);

    item_t      dec;
    item_t      entry_reg [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       push;

    // Field split of a command byte; long form takes its code from bits 4..2
    always_comb
    begin
        dec.op      = s_tuser;
        dec.data    = s_tdata;
        dec.is_end  = (s_tdata == END_MARK);
        dec.is_long = (s_tdata[7:5] == CMD_LONG);
        dec.code    = (s_tdata[7:5] == CMD_LONG) ? s_tdata[4:2] : s_tdata[7:5];
        dec.len_lo  = s_tdata[4:0];
        dec.len_hi  = s_tdata[1:0];
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

/* design/lzcd_back.sv */
// Back end: command state machine, history memory and output register.
`timescale 1ns / 1ps

module lzcd_back
    import lzcd_pkg::*;
#(
    parameter int HISTORY_DEPTH = 8192
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        q_valid,
    output logic        q_pop,
    input  item_t       q_item,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tuser
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int DW = AW + 1;
    localparam logic [16:0]   DEPTH_P = 17'(HISTORY_DEPTH);
    localparam logic [DW-1:0] DEPTH_D = DW'(HISTORY_DEPTH);
    localparam logic [AW-1:0] IDX_LAST = AW'(HISTORY_DEPTH - 1);

    // Architectural state
    phase_t        phase_reg, phase_next;
    logic [15:0]   write_pos_reg, write_pos_next;
    logic [AW-1:0] wr_idx_reg, wr_idx_next;
    logic [2:0]    command_reg, command_next;
    logic [10:0]   remaining_reg, remaining_next;
    logic [7:0]    value_a_reg, value_a_next;
    logic [7:0]    value_b_reg, value_b_next;
    logic [16:0]   source_pos_reg, source_pos_next;
    logic          run_odd_reg, run_odd_next;
    logic [2:0]    err_reg, err_next;
    logic          ended_reg, ended_next;
    logic [15:0]   limit_reg;

    // History memory and read forwarding
    logic [7:0]    hist_mem [HISTORY_DEPTH];
    logic [7:0]    rd_data_reg;
    logic          byp_reg;
    logic [7:0]    byp_data_reg;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_dist;
    logic [DW-1:0] wi_ext;
    logic [DW-1:0] rd_sum;
    logic [16:0]   next_gap;
    logic          wr_en;
    logic [7:0]    wr_data;
    logic [7:0]    hist_byte;

    // Output register
    logic          m_tvalid_reg;
    logic          out_valid_reg;
    logic [31:0]   m_tdata_reg;

    // Step conditions
    logic          step;
    logic          active;
    logic          go;
    logic          full;
    logic          is_copy;
    logic          range_bad;
    logic [16:0]   wp_ext;
    logic [16:0]   src_gap;
    logic          run_last;
    logic          put;
    logic [7:0]    emit_val;
    logic [2:0]    status;
    logic          want_byte;

    assign step   = q_valid && (!m_tvalid_reg || m_tready);
    assign q_pop  = step;
    assign active = step && !ended_reg && (err_reg == ST_OK);
    assign go     = active && (q_item.op == ((phase_reg == PH_EMIT) ? OP_TICK : OP_BYTE));

    // Limit and history range checks
    always_comb
    begin
        wp_ext    = {1'b0, write_pos_reg};
        full      = write_pos_reg[15] || (write_pos_reg >= limit_reg);
        src_gap   = wp_ext - source_pos_reg;
        range_bad = (source_pos_reg >= wp_ext) || (src_gap > DEPTH_P);
        is_copy   = (command_reg == CMD_COPY) || (command_reg == CMD_FLIP)
                    || (command_reg == CMD_BACK);
        run_last  = (remaining_reg == 11'd1);
        put       = go && !full
                    && ((phase_reg == PH_LIT)
                        || ((phase_reg == PH_EMIT) && !(is_copy && range_bad)));
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (go)
        begin
            unique case (phase_reg)
                PH_CMD:
                begin
                    if (!q_item.is_end && !full)
                    begin
                        if (!q_item.is_long)
                        begin
                            phase_next = start_phase(q_item.code);
                        end
                        else if (q_item.code != CMD_LONG)
                        begin
                            phase_next = PH_LONG;
                        end
                    end
                end
                PH_LONG:   phase_next = start_phase(command_reg);
                PH_LIT:    phase_next = (put && run_last) ? PH_CMD : PH_LIT;
                PH_VAL_A:  phase_next = (command_reg == CMD_ALT) ? PH_VAL_B : PH_EMIT;
                PH_VAL_B:  phase_next = PH_EMIT;
                PH_OFS_HI: phase_next = q_item.data[7] ? PH_EMIT : PH_OFS_LO;
                PH_OFS_LO: phase_next = PH_EMIT;
                PH_EMIT:   phase_next = (put && run_last) ? PH_CMD : PH_EMIT;
            endcase
        end
    end

    // Byte produced by a run step
    always_comb
    begin
        hist_byte = byp_reg ? byp_data_reg : rd_data_reg;
        unique case (command_reg)
            CMD_REPEAT: emit_val = value_a_reg;
            CMD_ALT:    emit_val = run_odd_reg ? value_b_reg : value_a_reg;
            CMD_COPY:   emit_val = hist_byte;
            CMD_FLIP:   emit_val = flip_bits(hist_byte);
            CMD_BACK:   emit_val = hist_byte;
            default:    emit_val = 8'd0;
        endcase
        wr_data = (phase_reg == PH_LIT) ? q_item.data : emit_val;
        wr_en   = put;
    end

    // Datapath state and result fields
    always_comb
    begin
        write_pos_next  = write_pos_reg;
        wr_idx_next     = wr_idx_reg;
        command_next    = command_reg;
        remaining_next  = remaining_reg;
        value_a_next    = value_a_reg;
        value_b_next    = value_b_reg;
        source_pos_next = source_pos_reg;
        run_odd_next    = run_odd_reg;
        err_next        = err_reg;
        ended_next      = ended_reg;

        if (go)
        begin
            unique case (phase_reg)
                PH_CMD:
                begin
                    if (q_item.is_end)
                    begin
                        ended_next = 1'b1;
                    end
                    else if (full)
                    begin
                        err_next = ST_TOO_LARGE;
                    end
                    else if (q_item.is_long)
                    begin
                        command_next = q_item.code;
                        if (q_item.code == CMD_LONG)
                        begin
                            err_next = ST_BAD_CMD;
                        end
                        else
                        begin
                            remaining_next = {1'b0, q_item.len_hi, 8'd0};
                        end
                    end
                    else
                    begin
                        command_next   = q_item.code;
                        remaining_next = 11'(q_item.len_lo) + 11'd1;
                        run_odd_next   = 1'b0;
                    end
                end
                PH_LONG:
                begin
                    remaining_next = remaining_reg + 11'(q_item.data) + 11'd1;
                    run_odd_next   = 1'b0;
                end
                PH_LIT:
                begin
                    if (full)
                    begin
                        err_next = ST_TOO_LARGE;
                    end
                end
                PH_VAL_A:  value_a_next = q_item.data;
                PH_VAL_B:  value_b_next = q_item.data;
                PH_OFS_HI:
                begin
                    if (q_item.data[7])
                    begin
                        // relative offset wraps modulo 2^17 below position 0
                        source_pos_next = wp_ext - 17'(q_item.data[6:0]) - 17'd1;
                    end
                    else
                    begin
                        value_a_next = q_item.data;
                    end
                end
                PH_OFS_LO: source_pos_next = {1'b0, value_a_reg, q_item.data};
                PH_EMIT:
                begin
                    if (full)
                    begin
                        err_next = ST_TOO_LARGE;
                    end
                    else if (is_copy)
                    begin
                        if (range_bad)
                        begin
                            err_next = ST_RANGE;
                        end
                        else if (command_reg == CMD_BACK)
                        begin
                            source_pos_next = source_pos_reg - 17'd1;
                        end
                        else
                        begin
                            source_pos_next = source_pos_reg + 17'd1;
                        end
                    end
                end
            endcase
        end

        // Byte written: advance position and run counters
        if (put)
        begin
            write_pos_next = write_pos_reg + 16'd1;
            wr_idx_next    = (wr_idx_reg == IDX_LAST) ? '0 : wr_idx_reg + AW'(1);
            remaining_next = remaining_reg - 11'd1;
            run_odd_next   = !run_odd_reg;
        end

        if (!active)
        begin
            status = err_reg;
        end
        else if (!go)
        begin
            status = ST_KIND;
        end
        else
        begin
            status = err_next;
        end
        want_byte = !ended_next && (err_next == ST_OK) && (phase_next != PH_EMIT);
    end

    // Prefetch address: ring slot of the next source position, found from
    // its distance behind the write slot
    always_comb
    begin
        next_gap = {1'b0, write_pos_next} - source_pos_next;
        rd_dist  = next_gap[DW-1:0];
        wi_ext   = {1'b0, wr_idx_next};
        rd_sum   = (wi_ext >= rd_dist) ? (wi_ext - rd_dist) : (wi_ext + DEPTH_D - rd_dist);
        rd_addr  = (rd_sum < DEPTH_D) ? rd_sum[AW-1:0] : '0;
    end

    // History memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[wr_idx_reg] <= wr_data;
        end
        rd_data_reg  <= hist_mem[rd_addr];
        byp_data_reg <= wr_data;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_CMD;
            write_pos_reg  <= 16'd0;
            wr_idx_reg     <= '0;
            command_reg    <= CMD_LITERAL;
            remaining_reg  <= 11'd0;
            value_a_reg    <= 8'd0;
            value_b_reg    <= 8'd0;
            source_pos_reg <= 17'd0;
            run_odd_reg    <= 1'b0;
            err_reg        <= ST_OK;
            ended_reg      <= 1'b0;
            limit_reg      <= LIMIT_RESET;
            byp_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            write_pos_reg  <= write_pos_next;
            wr_idx_reg     <= wr_idx_next;
            command_reg    <= command_next;
            remaining_reg  <= remaining_next;
            value_a_reg    <= value_a_next;
            value_b_reg    <= value_b_next;
            source_pos_reg <= source_pos_next;
            run_odd_reg    <= run_odd_next;
            err_reg        <= err_next;
            ended_reg      <= ended_next;
            byp_reg        <= wr_en && (wr_idx_reg == rd_addr);
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (step)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_valid_reg <= put;
            m_tdata_reg   <= {4'd0, status, ended_next, want_byte,
                              put ? write_pos_reg[14:0] : 15'd0,
                              put ? wr_data : 8'd0};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = out_valid_reg;

endmodule

/* design/lz_command_decompressor_unit.sv */
// Top level of the LZ / run-length command stream decompressor.
`timescale 1ns / 1ps

// Usage:
//   Slave stream: one item per handshake, either a compressed byte
//   (s_tuser = 0, byte in s_tdata) or a tick (s_tuser = 1) that asks for the
//   next byte of a running repeat, alternate, zero or history copy.
//   Master stream: exactly one result item per input item, in order. m_tuser
//   flags a produced byte; m_tdata carries byte, position, want-byte hint,
//   end flag and status.
//   cfg_wr_en / cfg_wr_data set the output byte limit; write only when idle.
//   A result passes through the queue and the output register before it
//   shows on m_tvalid. Throughput: one item per cycle, sustained while
//   m_tready is high; the history memory is read ahead at the next source
//   position, with a forward of the byte written in the same cycle.
//   A two-entry queue sits between the input decoder and the executing
//   stage; when m_tready is low the output register holds, the queue fills
//   and s_tready falls once it holds two items.
//   Reset clears all decoder state and sets the limit to 8192. The history
//   memory needs no clearing: only positions already written are ever read.
module lz_command_decompressor_unit
    import lzcd_pkg::*;
#(
    parameter int HISTORY_DEPTH = 8192
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // out_limit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] in_byte
    input  logic        s_tuser,       // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // [7:0] out_byte, [22:8] out_index,
                                       // [23] want_byte, [24] finished,
                                       // [27:25] status, [31:28] zero
    output logic        m_tuser        // [0] out_valid
);

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    lzcd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    lzcd_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
